// ===== rtl/efd_pkg.sv =====
`timescale 1ns / 1ps

package efd_pkg;

	localparam int BUFFER_SIZE_DEF = 256;
	localparam int LEN_BYTES = 4;

	localparam logic [7:0] ESC_CHAR     = 8'h2F;
	localparam logic [7:0] START_CHAR   = 8'h73;
	localparam logic [7:0] END_CHAR     = 8'h65;
	localparam logic [7:0] LITERAL_CHAR = 8'h61;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_END     = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_LEN_ERR    = 3'd2,
		ST_NO_CMD     = 3'd3,
		ST_OVERFLOW   = 3'd4,
		ST_FORMAT     = 3'd5,
		ST_NO_START   = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [7:0]  position;
		logic [7:0]  frame_cmd;
		logic [2:0]  status;
		logic [31:0] payload_length;
	} out_item_t;

endpackage

// ===== rtl/efd_stream_if.sv =====
`timescale 1ns / 1ps

interface efd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/efd_core.sv =====
`timescale 1ns / 1ps

module efd_core import efd_pkg::*; #(
	parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  logic [7:0] byte_s1,
	output logic      has_result,
	output out_item_t result
);

	localparam int IDX_W = $clog2(BUFFER_SIZE + 1);

	logic             esc_q, started_q, cmd_seen_q;
	logic [7:0]       cmd_q;
	logic [IDX_W-1:0] widx_q;
	logic [31:0]      bcount_q, len_q;

	logic             esc_d, started_d, cmd_seen_d;
	logic [7:0]       cmd_d;
	logic [IDX_W-1:0] widx_d;
	logic [31:0]      bcount_d, len_d;

	logic             do_store;
	logic [7:0]       store_val;
	logic [IDX_W+7:0] pos_ext;
	logic [2:0]       end_status;

	assign pos_ext = {8'd0, widx_q};

	// status of a frame end when a command was seen
	always_comb begin
		if (widx_q == '0) begin
			end_status = ST_EMPTY;
		end else if (widx_q < IDX_W'(LEN_BYTES)) begin
			end_status = ST_LEN_ERR;
		end else if ({1'b0, bcount_q} != ({1'b0, len_q} + 33'(LEN_BYTES))) begin
			end_status = ST_LEN_ERR;
		end else begin
			end_status = ST_OK;
		end
	end

	always_comb begin
		esc_d      = esc_q;
		started_d  = started_q;
		cmd_seen_d = cmd_seen_q;
		cmd_d      = cmd_q;
		widx_d     = widx_q;
		bcount_d   = bcount_q;
		len_d      = len_q;
		do_store   = 1'b0;
		store_val  = byte_s1;
		has_result = 1'b0;
		result     = '0;

		if (widx_q == IDX_W'(BUFFER_SIZE)) begin
			// buffer full: drop the beat
			widx_d        = '0;
			esc_d         = 1'b0;
			has_result    = 1'b1;
			result.kind   = KIND_ERROR;
			result.status = ST_OVERFLOW;
		end else if (byte_s1 == ESC_CHAR) begin
			esc_d = 1'b1;
		end else if (!esc_q) begin
			do_store = 1'b1;
		end else begin
			esc_d = 1'b0;
			if (byte_s1 == LITERAL_CHAR) begin
				do_store  = 1'b1;
				store_val = ESC_CHAR;
			end else if (byte_s1 == START_CHAR) begin
				started_d = 1'b1;
				widx_d    = '0;
				bcount_d  = '0;
				len_d     = '0;
			end else if (byte_s1 == END_CHAR) begin
				has_result            = 1'b1;
				result.kind           = KIND_END;
				result.payload_length = len_q;
				if (!cmd_seen_q) begin
					result.status = ST_NO_CMD;
				end else begin
					result.frame_cmd = cmd_q;
					result.status    = end_status;
				end
				started_d  = 1'b0;
				cmd_seen_d = 1'b0;
				widx_d     = '0;
				bcount_d   = '0;
				len_d      = '0;
			end else if (!started_q) begin
				has_result    = 1'b1;
				result.kind   = KIND_ERROR;
				result.status = ST_NO_START;
			end else if (widx_q != '0) begin
				// command after data aborts the frame
				started_d     = 1'b0;
				cmd_seen_d    = 1'b0;
				widx_d        = '0;
				bcount_d      = '0;
				has_result    = 1'b1;
				result.kind   = KIND_ERROR;
				result.status = ST_FORMAT;
			end else begin
				cmd_seen_d = 1'b1;
				cmd_d      = byte_s1;
			end
		end

		if (do_store) begin
			if (widx_q < IDX_W'(LEN_BYTES)) begin
				case (widx_q[1:0])
					2'd0:    len_d[7:0]   = store_val;
					2'd1:    len_d[15:8]  = store_val;
					2'd2:    len_d[23:16] = store_val;
					2'd3:    len_d[31:24] = store_val;
					default: len_d        = len_q;
				endcase
			end
			bcount_d         = bcount_q + 32'd1;
			widx_d           = widx_q + IDX_W'(1);
			has_result       = 1'b1;
			result.kind      = KIND_PAYLOAD;
			result.data_byte = store_val;
			result.position  = pos_ext[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q      <= 1'b0;
			started_q  <= 1'b0;
			cmd_seen_q <= 1'b0;
			cmd_q      <= '0;
			widx_q     <= '0;
			bcount_q   <= '0;
			len_q      <= '0;
		end else if (fire) begin
			esc_q      <= esc_d;
			started_q  <= started_d;
			cmd_seen_q <= cmd_seen_d;
			cmd_q      <= cmd_d;
			widx_q     <= widx_d;
			bcount_q   <= bcount_d;
			len_q      <= len_d;
		end
	end

endmodule

// ===== rtl/escaped_frame_decoder_top.sv =====
// a beat is held in the input register, its result in the output register
// throughput: one input beat per cycle, unless the output register holds a
// result not yet taken; the held beat is decoded against the frame state
// a beat that causes no result leaves the output register untouched
// arst_n clears the frame state, the escape flag and both valid flags
`timescale 1ns / 1ps

module escaped_frame_decoder_top import efd_pkg::*; #(
	parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	efd_stream_if.sink   stream,
	efd_stream_if.source result
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       proc;
	logic       has_res;
	out_item_t  res;

	// the held beat is decoded once the output register can take its result
	assign proc         = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || proc;

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	efd_core #(
		.BUFFER_SIZE(BUFFER_SIZE)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (proc),
		.byte_s1    (byte_s1),
		.has_result (has_res),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.payload.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && has_res) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && has_res) begin
			out_q <= res;
		end
	end

endmodule
